// File: design/anau_pkg.sv
// ----------------------------------------------------------------------------
// anau_pkg
// Types and constants shared by the Annex B NAL / access-unit splitter.
// ----------------------------------------------------------------------------
package anau_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int OUT_W           = 32;
	localparam int CODE_SIZE_W     = 3;
	localparam int TYPE_W          = 5;
	localparam int IN_DATA_W       = 8;
	localparam int OUT_DATA_W      = 80;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// output tdata bit positions
	localparam int OFS_LSB  = 0;
	localparam int LEN_LSB  = 32;
	localparam int CSZ_LSB  = 64;
	localparam int TYPE_LSB = 67;
	localparam int HDR_BIT  = 72;
	localparam int AU_BIT   = 73;

	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [7:0] START_BYTE = 8'h01;

	localparam logic [TYPE_W-1:0] TYPE_MASK   = 5'h1F;
	localparam logic [TYPE_W-1:0] TYPE_NONE   = 5'd0;
	localparam logic [TYPE_W-1:0] TYPE_SPS    = 5'd7;
	localparam logic [TYPE_W-1:0] TYPE_VCL_LO = 5'd1;
	localparam logic [TYPE_W-1:0] TYPE_VCL_HI = 5'd5;

	localparam logic [CODE_SIZE_W-1:0] CODE3 = 3'd3;
	localparam logic [CODE_SIZE_W-1:0] CODE4 = 3'd4;

	typedef struct packed {
		logic [OUT_W-1:0]       nal_offset;
		logic [OUT_W-1:0]       nal_length;
		logic [CODE_SIZE_W-1:0] code_size;
		logic [TYPE_W-1:0]      unit_type;
		logic                   header_present;
		logic                   begins_access_unit;
		logic                   final_unit;
	} result_t;

	typedef struct packed {
		logic any_au;
		logic prev_vcl;
		logic cur_vcl;
	} au_state_t;

endpackage

// File: design/annexb_nal_and_access_unit_splitter_unit.sv
// ----------------------------------------------------------------------------
// annexb_nal_and_access_unit_splitter_unit
// Scans an H.264 Annex B byte stream for start codes and reports each NAL
// unit with its offset, length, code size, type and access-unit start mark.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while s_axis_tready is high. Every
// accepted byte updates the parser state in the same cycle and can close up
// to two NAL units (one at a start code, one at the stream end); the results
// go into a registered 4-entry output queue. s_axis_tready is high while the
// queue has room for two results, so with the master side taking a result
// each cycle the block runs at one byte per clock indefinitely.
// Offsets and lengths above 2^32 - 1 read as all ones.
module annexb_nal_and_access_unit_splitter_unit #(
	parameter int OFFSET_BITS = anau_pkg::OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [anau_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] stream_byte
	input  logic                            s_axis_tlast,  // last_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [31:0] nal_offset, [63:32] nal_length, [66:64] code_size,
	// [71:67] unit_type, [72] header_present, [73] begins_access_unit, pad
	output logic [anau_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast   // final_unit
);
	import anau_pkg::*;

	localparam int LW   = OFFSET_BITS + 1;
	localparam int WIDE = (LW > OUT_W) ? LW : OUT_W + 1;
	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	logic [OFFSET_BITS-1:0] position_q;
	logic [7:0]             recent0_q, recent1_q, recent2_q;
	logic                   pend_valid_q;
	logic [OFFSET_BITS-1:0] pend_offset_q;
	logic                   pend_four_q;
	logic [TYPE_W-1:0]      pend_type_q;
	logic                   pend_hdr_q;
	au_state_t              au_q;

	result_t                queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]       count_q;

	logic                   accept, pop;
	logic [7:0]             b;
	logic                   hdr_now;
	logic [TYPE_W-1:0]      type_h;
	logic                   hdr_h;
	logic                   code_hit, four_hit;
	logic [OFFSET_BITS-1:0] code_off;
	logic [OFFSET_BITS-1:0] hdr_pos;
	result_t                res_a, res_b;
	au_state_t              au_a, au_b;
	logic                   a_v, b_v;
	logic                   n_pend_valid;
	logic [OFFSET_BITS-1:0] n_pend_offset;
	logic                   n_pend_four;
	logic [TYPE_W-1:0]      n_pend_type;
	logic                   n_pend_hdr;
	result_t                push0, push1;
	logic [1:0]             n_push;

	function automatic logic [OUT_W-1:0] sat_out(input logic [WIDE-1:0] v);
		sat_out = (|v[WIDE-1:OUT_W]) ? '1 : v[OUT_W-1:0];
	endfunction

	function automatic result_t close_unit(
		input  logic [OFFSET_BITS-1:0] p_off,
		input  logic                   four,
		input  logic [TYPE_W-1:0]      ptype,
		input  logic                   phdr,
		input  logic [LW-1:0]          end_pos,
		input  logic                   fin,
		input  au_state_t              au_in,
		output au_state_t              au_out
	);
		logic [LW-1:0]     len;
		logic [LW-1:0]     csize;
		logic              hdr;
		logic [TYPE_W-1:0] t;
		logic              vcl;
		logic              opens;
		result_t           r;
		len    = end_pos - {1'b0, p_off};
		csize  = four ? LW'(4) : LW'(3);
		hdr    = phdr && (len > csize);
		t      = hdr ? (ptype & TYPE_MASK) : TYPE_NONE;
		vcl    = (t >= TYPE_VCL_LO) && (t <= TYPE_VCL_HI);
		opens  = 1'b0;
		au_out = au_in;
		if (t == TYPE_SPS) begin
			opens           = 1'b1;
			au_out.any_au   = 1'b1;
			au_out.cur_vcl  = 1'b0;
			au_out.prev_vcl = 1'b0;
		end else if (vcl) begin
			if (!au_in.prev_vcl && (!au_in.any_au || au_in.cur_vcl)) begin
				opens         = 1'b1;
				au_out.any_au = 1'b1;
			end
			au_out.cur_vcl  = 1'b1;
			au_out.prev_vcl = 1'b1;
		end else begin
			if (!au_in.any_au) begin
				opens          = 1'b1;
				au_out.any_au  = 1'b1;
				au_out.cur_vcl = 1'b0;
			end
			au_out.prev_vcl = 1'b0;
		end
		r.nal_offset         = sat_out(WIDE'(p_off));
		r.nal_length         = sat_out(WIDE'(len));
		r.code_size          = four ? CODE4 : CODE3;
		r.unit_type          = t;
		r.header_present     = hdr;
		r.begins_access_unit = opens;
		r.final_unit         = fin;
		close_unit = r;
	endfunction

	assign s_axis_tready = (count_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (count_q != '0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign b             = s_axis_tdata;

	assign m_axis_tdata = {6'b0, queue_q[rd_ptr_q].begins_access_unit,
		queue_q[rd_ptr_q].header_present, queue_q[rd_ptr_q].unit_type,
		queue_q[rd_ptr_q].code_size, queue_q[rd_ptr_q].nal_length,
		queue_q[rd_ptr_q].nal_offset};
	assign m_axis_tlast = queue_q[rd_ptr_q].final_unit;

	always_comb begin
		hdr_pos  = pend_offset_q + (pend_four_q ? OFFSET_BITS'(4) : OFFSET_BITS'(3));
		hdr_now  = pend_valid_q && !pend_hdr_q && (position_q == hdr_pos);
		type_h   = hdr_now ? (b[TYPE_W-1:0] & TYPE_MASK) : pend_type_q;
		hdr_h    = pend_hdr_q || hdr_now;

		code_hit = (b == START_BYTE) && (position_q > OFFSET_BITS'(1))
			&& (position_q != POS_MAX) && (recent0_q == ZERO_BYTE)
			&& (recent1_q == ZERO_BYTE);
		four_hit = (position_q > OFFSET_BITS'(2)) && (recent2_q == ZERO_BYTE);
		code_off = position_q - (four_hit ? OFFSET_BITS'(3) : OFFSET_BITS'(2));

		a_v   = code_hit && pend_valid_q;
		res_a = close_unit(pend_offset_q, pend_four_q, type_h, hdr_h,
			{1'b0, code_off}, 1'b0, au_q, au_a);
		if (!a_v) begin
			au_a = au_q;
		end

		if (code_hit) begin
			n_pend_valid  = 1'b1;
			n_pend_offset = code_off;
			n_pend_four   = four_hit;
			n_pend_type   = TYPE_NONE;
			n_pend_hdr    = 1'b0;
		end else begin
			n_pend_valid  = pend_valid_q;
			n_pend_offset = pend_offset_q;
			n_pend_four   = pend_four_q;
			n_pend_type   = type_h;
			n_pend_hdr    = hdr_h;
		end

		b_v   = s_axis_tlast && n_pend_valid;
		res_b = close_unit(n_pend_offset, n_pend_four, n_pend_type, n_pend_hdr,
			{1'b0, position_q} + LW'(1), 1'b1, au_a, au_b);

		push0  = a_v ? res_a : res_b;
		push1  = res_b;
		n_push = {1'b0, a_v} + {1'b0, b_v};
	end

	always_ff @(posedge clk) begin
		if (accept && n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= push0;
		end
		if (accept && n_push == 2'd2) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (accept ? CNT_W'(n_push) : '0) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= '0;
			recent0_q     <= '0;
			recent1_q     <= '0;
			recent2_q     <= '0;
			pend_valid_q  <= 1'b0;
			pend_offset_q <= '0;
			pend_four_q   <= 1'b0;
			pend_type_q   <= '0;
			pend_hdr_q    <= 1'b0;
			au_q          <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				position_q    <= '0;
				recent0_q     <= '0;
				recent1_q     <= '0;
				recent2_q     <= '0;
				pend_valid_q  <= 1'b0;
				pend_offset_q <= '0;
				pend_four_q   <= 1'b0;
				pend_type_q   <= '0;
				pend_hdr_q    <= 1'b0;
				au_q          <= '0;
			end else begin
				if (position_q != POS_MAX) begin
					position_q <= position_q + OFFSET_BITS'(1);
				end
				recent0_q     <= b;
				recent1_q     <= recent0_q;
				recent2_q     <= recent1_q;
				pend_valid_q  <= n_pend_valid;
				pend_offset_q <= n_pend_offset;
				pend_four_q   <= n_pend_four;
				pend_type_q   <= n_pend_type;
				pend_hdr_q    <= n_pend_hdr;
				au_q          <= au_a;
			end
		end
	end

endmodule

// File: design/anau_checker.sv
// ----------------------------------------------------------------------------
// anau_checker
// Port-level checks for the Annex B NAL / access-unit splitter.
// ----------------------------------------------------------------------------
module anau_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [anau_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                            s_axis_tlast,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [anau_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast
);
	import anau_pkg::*;

	logic [CODE_SIZE_W-1:0] csz;
	logic [TYPE_W-1:0]      utype;
	assign csz   = m_axis_tdata[CSZ_LSB +: CODE_SIZE_W];
	assign utype = m_axis_tdata[TYPE_LSB +: TYPE_W];

	// stalled transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("output transaction changed while stalled");

	a_code_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (csz == CODE3) || (csz == CODE4))
		else $error("code size not 3 or 4");

	a_len_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[LEN_LSB +: OUT_W] >= OUT_W'(csz))
		else $error("unit shorter than its start code");

	a_no_hdr_type: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[HDR_BIT] |-> utype == TYPE_NONE)
		else $error("unit type set without header byte");

	a_hdr_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[HDR_BIT]
			|-> m_axis_tdata[LEN_LSB +: OUT_W] > OUT_W'(csz))
		else $error("header reported on a unit with no room for it");

endmodule

bind annexb_nal_and_access_unit_splitter_unit anau_checker u_anau_checker (.*);
